// File: hdl/gelk_pkg.sv
`timescale 1ns / 1ps

package gelk_pkg;

  localparam int DataWidth = 32;
  localparam int SumWidth  = 48;
  localparam int VarWidth  = 63;
  localparam int SqWidth   = 64;
  localparam int DivSteps  = SqWidth + 15;

  // Fixed constants in the log and offset path.
  localparam logic [31:0] Ln2Q32 = 32'd2977044472;
  // 16*ln2 minus ln(sqrt(2*pi)), both Q.16.
  localparam logic signed [SumWidth:0] LnOffset = 49'sd666593;

  localparam logic signed [SumWidth:0] SumMax = 49'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [SumWidth:0] SumMin = -49'sh0_8000_0000_0000;

  // Configuration register indexes.
  localparam logic [1:0] RegMean   = 2'd0;
  localparam logic [1:0] RegSigma  = 2'd1;
  localparam logic [1:0] RegMode   = 2'd2;
  localparam logic [1:0] RegTarget = 2'd3;

  // One classified sample on its way to the back end.
  typedef struct packed {
    logic [VarWidth-1:0] var_q;
    logic [SqWidth-1:0]  dev_sq;
    logic                last;
  } sample_t;

endpackage

// File: hdl/gelk_front.sv
`timescale 1ns / 1ps

module gelk_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [31:0]     sample_value,
  input  logic [30:0]            sample_error,
  input  logic                   last_sample,
  input  logic signed [31:0]     model_mean,
  input  logic [30:0]            model_sigma,
  output logic                   push,
  input  logic                   full,
  output gelk_pkg::sample_t      push_data
);

  logic        f_valid;
  logic [31:0] f_ad;
  logic [30:0] f_e;
  logic        f_last;
  logic signed [32:0] dev;
  logic [32:0] dev_abs;
  logic [61:0] e_sq;
  logic [61:0] s_sq;

  // Absolute deviation from the mean always fits in 32 bits.
  always_comb begin
    dev     = 33'(sample_value) - 33'(model_mean);
    dev_abs = dev[32] ? 33'(-dev) : 33'(dev);
  end

  assign push     = f_valid && !full;
  assign in_ready = !f_valid || !full;

  // Input register stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (in_ready) begin
      f_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      f_ad   <= dev_abs[31:0];
      f_e    <= sample_error;
      f_last <= last_sample;
    end
  end

  // Variance and squared deviation from the registered operands.
  always_comb begin
    e_sq = 62'(f_e) * 62'(f_e);
    s_sq = 62'(model_sigma) * 62'(model_sigma);
    push_data.var_q  = 63'(e_sq) + 63'(s_sq);
    push_data.dev_sq = 64'(f_ad) * 64'(f_ad);
    push_data.last   = f_last;
  end

endmodule

// File: hdl/gelk_fifo.sv
`timescale 1ns / 1ps

module gelk_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  gelk_pkg::sample_t  push_data,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output gelk_pkg::sample_t  pop_data
);

  gelk_pkg::sample_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_data  = mem[rd_ptr];

  // Two-entry queue between front and back.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
    if (push) mem[wr_ptr] <= push_data;
  end

endmodule

// File: hdl/gelk_back.sv
`timescale 1ns / 1ps

module gelk_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                avail,
  input  gelk_pkg::sample_t   item,
  output logic                pop,
  input  logic                output_mode,
  input  logic signed [47:0]  target_level,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [47:0]         likelihood_value,
  output logic                domain_error
);

  typedef enum logic [2:0] {
    IDLE, RUN, SQUARE, MULT, TERM, ACCUM, EMIT
  } state_t;

  state_t state;
  logic [62:0] var_q;
  logic [63:0] dsh;
  logic [63:0] rem;
  logic [47:0] quo;
  logic        ovf;
  logic [6:0]  step;
  logic [63:0] nv;
  logic [5:0]  lead;
  logic [30:0] y;
  logic [15:0] frac;
  logic [3:0]  sq_cnt;
  logic [53:0] prod;
  logic signed [48:0] term;
  logic        last;
  logic signed [47:0] running_sum;
  logic        error_seen;

  logic [63:0] rem_next;
  logic        ge;
  logic [47:0] quo_next;
  logic [61:0] y_sq;
  logic [31:0] y_next;
  logic [21:0] half;
  logic signed [48:0] term_raw;
  logic signed [48:0] sum_raw;
  logic signed [48:0] diff;
  logic [48:0] diff_abs;
  logic        out_free;

  assign pop      = (state == IDLE) && avail;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    // One restoring division step.
    rem_next = {rem[62:0], dsh[63]};
    ge       = (rem_next >= 64'(var_q));
    quo_next = {quo[46:0], ge};
    // One squaring step of the log mantissa.
    y_sq   = 62'(y) * 62'(y);
    y_next = y_sq[61:30];
    // Rounded half natural log, then the per-sample term.
    half     = 22'((prod + 54'h1_0000_0000) >> 33);
    term_raw = 49'(half) - gelk_pkg::LnOffset + 49'({1'b0, ovf ? 48'h7FFF_FFFF_FFFF : quo});
    sum_raw  = 49'(running_sum) + term;
    diff     = 49'(running_sum) - 49'(target_level);
    diff_abs = diff[48] ? 49'(-diff) : 49'(diff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      out_valid   <= 1'b0;
      running_sum <= '0;
      error_seen  <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != EMIT) out_valid <= 1'b0;
      case (state)
        IDLE: begin
          if (avail) begin
            var_q <= item.var_q;
            dsh   <= item.dev_sq;
            nv    <= 64'(item.var_q);
            last  <= item.last;
            rem   <= '0;
            quo   <= '0;
            ovf   <= 1'b0;
            lead  <= 6'd63;
            step  <= 7'(gelk_pkg::DivSteps - 1);
            frac  <= '0;
            if (item.var_q == '0) begin
              error_seen <= 1'b1;
              state      <= item.last ? EMIT : IDLE;
            end else begin
              state <= RUN;
            end
          end
        end
        // Long division and leading-one search run side by side.
        RUN: begin
          rem  <= ge ? rem_next - 64'(var_q) : rem_next;
          quo  <= quo_next;
          ovf  <= ovf | quo_next[47];
          dsh  <= {dsh[62:0], 1'b0};
          if (!nv[63] && lead != 6'd0) begin
            nv   <= {nv[62:0], 1'b0};
            lead <= lead - 6'd1;
          end
          step <= step - 7'd1;
          if (step == 7'd0) begin
            y      <= nv[63:33];
            sq_cnt <= 4'd15;
            state  <= SQUARE;
          end
        end
        // Log fraction bits by repeated squaring.
        SQUARE: begin
          y      <= y_next[31] ? y_next[31:1] : y_next[30:0];
          frac   <= {frac[14:0], y_next[31]};
          sq_cnt <= sq_cnt - 4'd1;
          if (sq_cnt == 4'd0) state <= MULT;
        end
        MULT: begin
          prod  <= 54'({lead, frac}) * 54'(gelk_pkg::Ln2Q32);
          state <= TERM;
        end
        TERM: begin
          if (ovf || term_raw > gelk_pkg::SumMax) error_seen <= 1'b1;
          if (term_raw > gelk_pkg::SumMax) begin
            term <= gelk_pkg::SumMax;
          end else begin
            term <= term_raw;
          end
          state <= ACCUM;
        end
        ACCUM: begin
          if (sum_raw > gelk_pkg::SumMax) begin
            running_sum <= gelk_pkg::SumMax[47:0];
            error_seen  <= 1'b1;
          end else if (sum_raw < gelk_pkg::SumMin) begin
            running_sum <= gelk_pkg::SumMin[47:0];
            error_seen  <= 1'b1;
          end else begin
            running_sum <= sum_raw[47:0];
          end
          state <= last ? EMIT : IDLE;
        end
        // Wait for the output register, then deliver and clear.
        EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (output_mode) begin
              if (diff_abs > 49'(gelk_pkg::SumMax)) begin
                likelihood_value <= gelk_pkg::SumMax[47:0];
                domain_error     <= 1'b1;
              end else begin
                likelihood_value <= diff_abs[47:0];
                domain_error     <= error_seen;
              end
            end else begin
              likelihood_value <= running_sum;
              domain_error     <= error_seen;
            end
            running_sum <= '0;
            error_seen  <= 1'b0;
            state       <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// File: hdl/gaussian_error_loglik_accumulator.sv
`timescale 1ns / 1ps

// Gaussian negative log-likelihood accumulator.
// Input stream (s_*): one sample per transaction; tdata carries sample_value
// and sample_error, tlast marks the final sample of a data set.
// Output stream (m_*): one transaction per data set, after its last sample;
// tdata is the Q32.16 sum (or its distance from target_level in mode 1),
// tuser is the sticky domain_error flag.
// Configuration: cfg_we/cfg_index/cfg_data write model_mean, model_sigma,
// output_mode and target_level; write only while the block is idle.
// In the back end each sample leaves the queue, then runs a one-bit long
// division (the leading-one search runs alongside), 16 squaring steps for the
// log fraction, then a multiply, a term and an accumulate step. A sample with
// zero variance skips the arithmetic and sets the error flag. The front register
// and a two-entry queue keep accepting samples while the back end works.
// Reset clears the sum, the error flag, the queue and loads default config.
// A stalled receiver holds the result; the back end keeps working on queued
// samples until its next result is ready, then waits.

module gaussian_error_loglik_accumulator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [31:0] sample_value, [62:32] sample_error
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [47:0] likelihood_value
  output logic        m_tuser,   // [0] domain_error
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  logic signed [31:0] model_mean;
  logic [30:0]        model_sigma;
  logic               output_mode;
  logic signed [47:0] target_level;

  logic              push;
  logic              full;
  logic              pop;
  logic              not_empty;
  gelk_pkg::sample_t push_data;
  gelk_pkg::sample_t pop_data;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      model_mean   <= '0;
      model_sigma  <= 31'd65536;
      output_mode  <= 1'b0;
      target_level <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        gelk_pkg::RegMean:   model_mean   <= cfg_data[31:0];
        gelk_pkg::RegSigma:  model_sigma  <= cfg_data[30:0];
        gelk_pkg::RegMode:   output_mode  <= cfg_data[0];
        gelk_pkg::RegTarget: target_level <= cfg_data;
        default: ;
      endcase
    end
  end

  gelk_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .sample_value (s_tdata[31:0]),
    .sample_error (s_tdata[62:32]),
    .last_sample  (s_tlast),
    .model_mean   (model_mean),
    .model_sigma  (model_sigma),
    .push         (push),
    .full         (full),
    .push_data    (push_data)
  );

  gelk_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .pop_data  (pop_data)
  );

  gelk_back u_back (
    .clk              (clk),
    .rst              (rst),
    .avail            (not_empty),
    .item             (pop_data),
    .pop              (pop),
    .output_mode      (output_mode),
    .target_level     (target_level),
    .out_valid        (m_tvalid),
    .out_ready        (m_tready),
    .likelihood_value (m_tdata),
    .domain_error     (m_tuser)
  );

endmodule
